@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/tpg_pkg.sv @@
// Package for the three-pool Gillespie step: widths, word types, states.
// No dependencies.
`timescale 1ns / 1ps
package tpg_pkg;
    localparam int COUNT_BITS    = 16;
    localparam int NUM_REACTIONS = 8;
    localparam int RATE_W        = 24;
    localparam int IDX_W         = $clog2(NUM_REACTIONS);
    localparam int CUM_W         = RATE_W + COUNT_BITS + IDX_W;
    localparam int DVD_W         = 40;
    localparam int CFG_IDX_W     = 8;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic        op;
        logic [15:0] init_b;
        logic [15:0] init_l;
        logic [15:0] init_s;
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic [31:0] uniform_draw;
        logic [31:0] exp_draw;
    } in_word_t;

    typedef struct packed {
        logic [15:0] count_b;
        logic [15:0] count_l;
        logic [15:0] count_s;
        logic [31:0] time_now;
        logic [2:0]  event_index;
        logic        event_valid;
        logic [1:0]  finish_cause;
    } out_word_t;

    localparam logic OP_START = 1'b0;
    localparam logic [1:0] CAUSE_RUN  = 2'd0;
    localparam logic [1:0] CAUSE_EXT  = 2'd1;
    localparam logic [1:0] CAUSE_END  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_DECIDE, ST_DIV_GO, ST_DIV, ST_TGT_LO, ST_TGT_HI,
        ST_TGT_SUM, ST_SCAN, ST_OUT
    } state_t;
endpackage

@@ hw/rtl/tpg_mul.sv @@
// Shared 32x32 multiplier with registered product.
// Depends on nothing.
`timescale 1ns / 1ps
module tpg_mul (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] p_reg;
    always_ff @(posedge aclk) begin
        p_reg <= 64'(a) * 64'(b);
    end
    assign p = p_reg;
endmodule

@@ hw/rtl/tpg_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on tpg_pkg.
`timescale 1ns / 1ps
module tpg_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [tpg_pkg::DVD_W-1:0] dividend,
    input  logic [tpg_pkg::CUM_W-1:0] divisor,
    output logic                     done,
    output logic [tpg_pkg::DVD_W-1:0] quotient
);
    import tpg_pkg::*;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CUM_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CUM_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [CUM_W:0]   trial;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                // shift dividend bit in, quotient bit fills the vacated lsb
                if (trial >= {1'b0, dsr_reg}) begin
                    rem_reg <= CUM_W'(trial - {1'b0, dsr_reg});
                    quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[CUM_W-1:0];
                    quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

@@ hw/rtl/three_pool_gillespie_event_step_top.sv @@
// Top level of the three-pool Gillespie direct-method step.
// Depends on tpg_pkg, tpg_mul, tpg_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A start word (op 0) goes from the accepting cycle straight to the output
// state, where the result is loaded into the output register once it is free.
// A step word that applies an event is accepted, then computes the eight
// propensities on the shared multiplier, decides, runs the bit-serial divider
// for exp/total, forms the selection target on the multiplier, scans the
// cumulative rates (one cumulative rate per cycle) and loads the output. A
// step that halts on a halted run, a passed end time or a zero total skips the
// divider, target and scan; an overshoot halt skips the target and scan. The
// input is ready only while idle; a finished result sits in the output
// register, so the next word can be taken while the previous result still
// waits.
module three_pool_gillespie_event_step_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tpg_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tpg_pkg::out_word_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpg_pkg::RATE_W-1:0]     cfg_data
);
    import tpg_pkg::*;

    localparam int CNT_W = IDX_W + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    state_t state_reg, state_next;

    logic [RATE_W-1:0] rate_reg [NUM_REACTIONS];
    logic [CUM_W-1:0]  cum_reg  [NUM_REACTIONS];
    count_t            pop_b_reg, pop_l_reg, pop_s_reg;
    logic [31:0]       sim_reg, stop_reg;
    logic              halted_reg;
    in_word_t          in_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CUM_W-1:0]  acc_reg, target_reg;
    logic [31:0]       lo_hi_reg;
    logic [31:0]       tnew_reg;
    out_word_t         res_reg, out_reg;
    logic              out_valid_reg;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic              div_start, div_done;
    logic [DVD_W-1:0]  quo;
    logic [CUM_W-1:0]  acc_sum;
    logic [DVD_W:0]    t_sum;
    logic              out_free;
    logic [IDX_W-1:0]  ix;
    logic [1:0]        halt_cause;

    tpg_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_p));

    tpg_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend({in_reg.exp_draw, 8'b0}), .divisor(acc_reg),
        .done(div_done), .quotient(quo)
    );

    function automatic count_t load_sat(input logic [15:0] v);
        if (32'(v) > 32'(CMAX)) return CMAX;
        return COUNT_BITS'(v);
    endfunction
    function automatic count_t inc_sat(input count_t v);
        return (v == CMAX) ? v : v + 1'b1;
    endfunction
    function automatic count_t dec_sat(input count_t v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    assign ix       = cnt_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || m_ready;
    assign acc_sum  = acc_reg + mul_p[CUM_W-1:0];
    assign t_sum    = (DVD_W+1)'(sim_reg) + (DVD_W+1)'(quo);
    assign cfg_ready = 1'b1;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // early halt check once the total rate is in acc_reg
    assign halt_cause = halted_reg ? ((sim_reg < stop_reg && acc_reg == '0) ? CAUSE_EXT
                                                                           : CAUSE_END)
                      : (sim_reg >= stop_reg) ? CAUSE_END
                      : (acc_reg == '0) ? CAUSE_EXT : CAUSE_RUN;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_valid) state_next = (s_data.op == OP_START) ? ST_OUT : ST_MUL;
            ST_MUL:     if (cnt_reg == CNT_W'(NUM_REACTIONS)) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (halted_reg || halt_cause != CAUSE_RUN) state_next = ST_OUT;
                else state_next = ST_DIV_GO;
            end
            ST_DIV_GO:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_done)
                    state_next = (t_sum > (DVD_W+1)'(stop_reg)) ? ST_OUT : ST_TGT_LO;
            end
            ST_TGT_LO:  state_next = ST_TGT_HI;
            ST_TGT_HI:  state_next = ST_TGT_SUM;
            ST_TGT_SUM: state_next = ST_SCAN;
            ST_SCAN: begin
                if (cum_reg[ix] > target_reg || ix == IDX_W'(NUM_REACTIONS - 1))
                    state_next = ST_OUT;
            end
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_MUL: begin
                // per-capita pool: B for 0,1; L for 2,4,6; S for 3,5,7
                mul_a = 32'(rate_reg[ix]);
                if (ix < IDX_W'(2))  mul_b = 32'(pop_b_reg);
                else if (ix[0])      mul_b = 32'(pop_s_reg);
                else                 mul_b = 32'(pop_l_reg);
            end
            ST_DIV_GO: div_start = 1'b1;
            ST_TGT_LO: begin
                mul_a = in_reg.uniform_draw;
                mul_b = acc_reg[31:0];
            end
            ST_TGT_HI: begin
                mul_a = in_reg.uniform_draw;
                mul_b = 32'(acc_reg[CUM_W-1:32]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            halted_reg    <= 1'b1;
            pop_b_reg     <= '0;
            pop_l_reg     <= '0;
            pop_s_reg     <= '0;
            sim_reg       <= '0;
            stop_reg      <= '0;
            cnt_reg       <= '0;
            for (int i = 0; i < NUM_REACTIONS; i++) rate_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REACTIONS))
                rate_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
            if (state_reg == ST_OUT && out_free) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg  <= s_data;
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        if (s_data.op == OP_START) begin
                            pop_b_reg  <= load_sat(s_data.init_b);
                            pop_l_reg  <= load_sat(s_data.init_l);
                            pop_s_reg  <= load_sat(s_data.init_s);
                            sim_reg    <= s_data.start_time;
                            stop_reg   <= s_data.end_time;
                            halted_reg <= 1'b0;
                            tnew_reg   <= s_data.start_time;
                            res_reg    <= '{default: '0};
                        end
                    end
                end
                ST_MUL: begin
                    // product of the previous cycle's issue lands now
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_sum;
                        cum_reg[IDX_W'(cnt_reg - 1'b1)] <= acc_sum;
                    end
                    cnt_reg <= (cnt_reg == CNT_W'(NUM_REACTIONS)) ? '0 : cnt_reg + 1'b1;
                end
                ST_DECIDE: begin
                    tnew_reg <= sim_reg;
                    res_reg  <= '{finish_cause: halt_cause, default: '0};
                    if (halt_cause != CAUSE_RUN) halted_reg <= 1'b1;
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (t_sum > (DVD_W+1)'(stop_reg)) begin
                            halted_reg <= 1'b1;
                            res_reg.finish_cause <= CAUSE_END;
                        end else begin
                            tnew_reg <= t_sum[31:0];
                        end
                    end
                end
                ST_TGT_HI:  lo_hi_reg <= mul_p[63:32];
                ST_TGT_SUM: target_reg <= mul_p[CUM_W-1:0] + CUM_W'(lo_hi_reg);
                ST_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cum_reg[ix] > target_reg || ix == IDX_W'(NUM_REACTIONS - 1)) begin
                        res_reg <= '{event_index: 3'(ix), event_valid: 1'b1,
                                     finish_cause: CAUSE_RUN, default: '0};
                        sim_reg <= tnew_reg;
                        case (ix)
                            3'd0: begin
                                pop_b_reg <= dec_sat(pop_b_reg);
                                pop_l_reg <= inc_sat(pop_l_reg);
                            end
                            3'd1: begin
                                pop_b_reg <= dec_sat(pop_b_reg);
                                pop_s_reg <= inc_sat(pop_s_reg);
                            end
                            3'd2: begin
                                pop_b_reg <= inc_sat(pop_b_reg);
                                pop_l_reg <= dec_sat(pop_l_reg);
                            end
                            3'd3: begin
                                pop_b_reg <= inc_sat(pop_b_reg);
                                pop_s_reg <= dec_sat(pop_s_reg);
                            end
                            3'd4: pop_l_reg <= dec_sat(pop_l_reg);
                            3'd5: pop_s_reg <= dec_sat(pop_s_reg);
                            3'd6: pop_l_reg <= inc_sat(pop_l_reg);
                            default: pop_s_reg <= inc_sat(pop_s_reg);
                        endcase
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        out_reg <= '{count_b: 16'(pop_b_reg), count_l: 16'(pop_l_reg),
                                     count_s: 16'(pop_s_reg), time_now: tnew_reg,
                                     event_index: res_reg.event_index,
                                     event_valid: res_reg.event_valid,
                                     finish_cause: res_reg.finish_cause};
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_SAME(a_ev_running, aclk, aresetn,
        m_valid && m_data.event_valid, m_data.finish_cause == CAUSE_RUN)
    `ASSERT_NEXT(a_start_clears_halt, aclk, aresetn,
        s_valid && s_ready && s_data.op == OP_START, !halted_reg)
    `ASSERT_SAME(a_div_done_in_div, aclk, aresetn, div_done, state_reg == ST_DIV)
    `ASSERT_NEXT(a_out_loaded, aclk, aresetn, state_reg == ST_OUT && out_free, m_valid)
endmodule
